// ----- src/cpc_pkg.sv -----
// Shared types and constants for the complex projection chi-square unit.
// No dependencies.
package cpc_pkg;

  localparam int CFG_W     = 7;
  localparam int ROW_W     = 6;
  localparam int PAIR_W    = 5;
  localparam int VAL_W     = 32;
  localparam int CHISQ_W   = 64;
  localparam int KW        = 8;
  localparam int DIV_STEPS = 7;
  localparam int STEP_W    = 3;

  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

  localparam logic [0:0] CFG_ORTHO_COUNT = 1'b0;
  localparam logic [0:0] CFG_MAX_DOF     = 1'b1;

  localparam logic [CFG_W-1:0] ORTHO_COUNT_RST = 7'd1;
  localparam logic [CFG_W-1:0] MAX_DOF_RST     = 7'd5;

  typedef enum logic [1:0] {
    OP_LOAD_COEF  = 2'd0,
    OP_LOAD_ORTHO = 2'd1,
    OP_COMPUTE    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN,
    ST_DONE
  } state_e;

endpackage

// ----- src/cpc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/complex_projection_chisq_unit.sv -----
// Complex projection chi-square unit: coefficient/ortho tables in RAM, one MAC term per cycle.
// Loads are accepted back to back while idle.
// A compute item issues T = ceil(n / stride) rows; a gap, out-of-range pair or n = 0 item skips to the result.
// (stride divider, one row issued per cycle, 5-stage residual/square/accumulate pipe).
// Reset (async, active low): ortho_count = 1, max_dof = 5, no result pending; tables keep no reset.
// Depends on cpc_pkg and cpc_ram.
module complex_projection_chisq_unit
  import cpc_pkg::*;
#(
  parameter int MAX_ORTHO    = 64,
  parameter int MAX_PAIRS    = 32,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [0:0]                cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                opcode_i,
  input  logic [ROW_W-1:0]          row_index_i,
  input  logic [PAIR_W-1:0]         pair_index_i,
  input  logic signed [VAL_W-1:0]   value_re_i,
  input  logic signed [VAL_W-1:0]   value_im_i,
  input  logic                      gap_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [CHISQ_W-1:0]        chisq_o,
  output logic                      saturated_o
);

  localparam int OAW    = (MAX_ORTHO > 1) ? $clog2(MAX_ORTHO) : 1;
  localparam int CDEPTH = MAX_ORTHO * MAX_PAIRS;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int SW     = SAMPLE_WIDTH;

  localparam logic [8:0]  ORTHO_LIM = 9'(MAX_ORTHO);
  localparam logic [7:0]  PAIR_LIM  = 8'(MAX_PAIRS);
  localparam logic [15:0] PAIR_MUL  = 16'(MAX_PAIRS);

  localparam logic signed [64:0] S_POS = 65'sd1 <<< 62;
  localparam logic signed [64:0] S_NEG = -S_POS;
  localparam logic signed [63:0] RND   = 64'sd32768;
  localparam logic signed [47:0] R_HI  = (48'sd1 <<< (SW - 1)) - 48'sd1;
  localparam logic signed [47:0] R_LO  = -(48'sd1 <<< (SW - 1));

  // configuration
  logic [CFG_W-1:0] ortho_count_q, max_dof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ortho_count_q <= ORTHO_COUNT_RST;
      max_dof_q     <= MAX_DOF_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ORTHO_COUNT: ortho_count_q <= cfg_data_i;
        CFG_MAX_DOF:     max_dof_q     <= cfg_data_i;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // input decode
  op_e              op;
  logic             in_fire;
  logic             row_ok, pair_ok;
  logic [CFG_W-1:0] n_cur, dof_lim, dof_cur;
  logic             trivial;

  assign op      = op_e'(opcode_i);
  assign in_fire = in_valid_i && in_ready_o;
  assign row_ok  = 9'(row_index_i) < ORTHO_LIM;
  assign pair_ok = 8'(pair_index_i) < PAIR_LIM;
  assign n_cur   = (9'(ortho_count_q) > ORTHO_LIM) ? ORTHO_LIM[CFG_W-1:0] : ortho_count_q;
  assign dof_lim = (max_dof_q == '0) ? CFG_W'(1) : max_dof_q;
  assign dof_cur = (dof_lim > n_cur) ? n_cur : dof_lim;
  assign trivial = gap_i || !pair_ok || (n_cur == '0);

  // control
  state_e           state_q, state_d;
  logic             issue, out_load;
  logic [4:0]       v_q;
  logic [KW-1:0]    k_q;
  logic [CFG_W-1:0] n_q, dof_q, div_num_q, rem_q, quo_q;
  logic [STEP_W-1:0] step_q;
  logic             out_valid_q;

  always_comb begin
    state_d  = state_q;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && op == OP_COMPUTE) begin
          state_d = trivial ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_q == DIV_LAST) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        issue = k_q < KW'(n_q);
        if (!issue && v_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v_q     <= {v_q[3:0], issue};
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // stride = n / dof, one quotient bit per cycle
  logic [CFG_W:0] rem_sh;
  logic           div_ge;

  assign rem_sh = {rem_q, div_num_q[CFG_W-1]};
  assign div_ge = rem_sh >= {1'b0, dof_q};

  // tables
  logic [15:0]     caddr_w, caddr_r;
  logic [KW-1:0]   row_ext;
  logic            coef_we, ortho_we;
  logic [2*VAL_W-1:0] coef_rdata;
  logic [VAL_W-1:0]   ortho_rdata;
  logic [PAIR_W-1:0]  pair_q;

  assign caddr_w  = 16'(row_index_i) * PAIR_MUL + 16'(pair_index_i);
  assign caddr_r  = 16'(k_q) * PAIR_MUL + 16'(pair_q);
  assign row_ext  = KW'(row_index_i);
  assign coef_we  = in_fire && op == OP_LOAD_COEF && row_ok && pair_ok;
  assign ortho_we = in_fire && op == OP_LOAD_ORTHO && row_ok;

  cpc_ram #(
    .WIDTH (2 * VAL_W),
    .DEPTH (CDEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (caddr_w[CAW-1:0]),
    .wdata_i ({value_re_i, value_im_i}),
    .raddr_i (caddr_r[CAW-1:0]),
    .rdata_o (coef_rdata)
  );

  cpc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ORTHO)
  ) u_ortho_ram (
    .clk_i   (clk_i),
    .we_i    (ortho_we),
    .waddr_i (row_ext[OAW-1:0]),
    .wdata_i (value_re_i),
    .raddr_i (k_q[OAW-1:0]),
    .rdata_o (ortho_rdata)
  );

  // datapath
  logic signed [VAL_W-1:0]   vre_q, vim_q, mre, mim;
  logic signed [2*VAL_W-1:0] a_d, b_d, a_q, b_q;
  logic signed [VAL_W-1:0]   orth1_q, orth2_q;
  logic signed [64:0]        s_wide;
  logic signed [63:0]        s_cl, s_q, t_val;
  logic signed [47:0]        q_val;
  logic signed [SW-1:0]      r_d, r_q;
  logic                      r_sat;
  logic signed [2*SW-1:0]    prod;
  logic [CHISQ_W-1:0]        sq_q, sum_q, chisq_q;
  logic [CHISQ_W:0]          acc;
  logic                      sat_q, saturated_q;

  assign mre = coef_rdata[2*VAL_W-1:VAL_W];
  assign mim = coef_rdata[VAL_W-1:0];
  assign a_d = vre_q * mre;
  assign b_d = vim_q * mim;

  assign s_wide = $signed({a_q[63], a_q}) + $signed({b_q[63], b_q});

  always_comb begin
    if (s_wide > S_POS) begin
      s_cl = S_POS[63:0];
    end else if (s_wide < S_NEG) begin
      s_cl = S_NEG[63:0];
    end else begin
      s_cl = s_wide[63:0];
    end
  end

  assign t_val = s_q - $signed({{16{orth2_q[VAL_W-1]}}, orth2_q, 16'h0000}) + RND;
  assign q_val = t_val[63:16];

  always_comb begin
    r_sat = 1'b1;
    if (q_val > R_HI) begin
      r_d = R_HI[SW-1:0];
    end else if (q_val < R_LO) begin
      r_d = R_LO[SW-1:0];
    end else begin
      r_d   = q_val[SW-1:0];
      r_sat = 1'b0;
    end
  end

  assign prod = r_q * r_q;
  assign acc  = {1'b0, sum_q} + {1'b0, sq_q};

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    orth1_q <= ortho_rdata;
    s_q     <= s_cl;
    orth2_q <= orth1_q;
    r_q     <= r_d;
    sq_q    <= CHISQ_W'($unsigned(prod));

    if (in_fire && op == OP_COMPUTE) begin
      n_q       <= n_cur;
      dof_q     <= dof_cur;
      div_num_q <= n_cur;
      rem_q     <= '0;
      quo_q     <= '0;
      step_q    <= '0;
      k_q       <= '0;
      pair_q    <= pair_index_i;
      vre_q     <= value_re_i;
      vim_q     <= value_im_i;
      sum_q     <= '0;
      sat_q     <= 1'b0;
    end else begin
      if (state_q == ST_DIV) begin
        rem_q     <= div_ge ? CFG_W'(rem_sh - {1'b0, dof_q}) : rem_sh[CFG_W-1:0];
        quo_q     <= {quo_q[CFG_W-2:0], div_ge};
        div_num_q <= {div_num_q[CFG_W-2:0], 1'b0};
        step_q    <= step_q + STEP_W'(1);
      end
      if (issue) begin
        k_q <= k_q + KW'(quo_q);
      end
      if ((v_q[2] && r_sat) || (v_q[4] && acc[CHISQ_W])) begin
        sat_q <= 1'b1;
      end
      if (v_q[4]) begin
        sum_q <= acc[CHISQ_W] ? '1 : acc[CHISQ_W-1:0];
      end
    end

    if (out_load) begin
      chisq_q     <= sum_q;
      saturated_q <= sat_q;
    end
  end

  assign chisq_o     = chisq_q;
  assign saturated_o = saturated_q;

`ifndef ASSERT_OFF
  a_stride_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> quo_q != '0)
    else $error("stride is zero while rows are issued");

  a_dof_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> (dof_q != '0) && (dof_q <= n_q))
    else $error("divisor out of range");

  a_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_DONE) |-> v_q == '0)
    else $error("pipeline busy outside of row processing");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result shown without a finished item");
`endif

endmodule

// ----- sim/complex_projection_chisq_checker.sv -----
`timescale 1ns / 1ps
// Checker for the complex projection chi-square unit: watches the config, input and
// result channels, predicts each chi-square result and compares it. Depends on cpc_pkg.
module complex_projection_chisq_checker
  import cpc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [0:0]              cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [1:0]              opcode_i,
  input  logic [ROW_W-1:0]        row_index_i,
  input  logic [PAIR_W-1:0]       pair_index_i,
  input  logic signed [VAL_W-1:0] value_re_i,
  input  logic signed [VAL_W-1:0] value_im_i,
  input  logic                    gap_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [CHISQ_W-1:0]      chisq_i,
  input  logic                    saturated_i,
  output int                      mismatch_count_o,
  output int                      due_count_o
);

  localparam int ORTHO_ROWS = 64;
  localparam int PAIRS      = 32;

  localparam logic signed [65:0] SUM_CLAMP = 66'sd4611686018427387904;
  localparam logic signed [65:0] RES_MAX   = 66'sd2147483647;
  localparam logic signed [65:0] RES_MIN   = -66'sd2147483648;

  typedef struct packed {
    logic [CHISQ_W-1:0] chisq;
    logic               saturated;
  } chisq_result_t;

  logic signed [VAL_W-1:0] coef_re_tab [0:ORTHO_ROWS*PAIRS-1];
  logic signed [VAL_W-1:0] coef_im_tab [0:ORTHO_ROWS*PAIRS-1];
  logic signed [VAL_W-1:0] ortho_tab   [0:ORTHO_ROWS-1];
  logic [CFG_W-1:0]        ortho_count;
  logic [CFG_W-1:0]        max_dof;
  chisq_result_t           chisq_due_q [$];

  function automatic chisq_result_t projected_chisq(input logic signed [VAL_W-1:0] re,
                                                    input logic signed [VAL_W-1:0] im,
                                                    input logic [PAIR_W-1:0] pair,
                                                    input logic gap);
    chisq_result_t     res;
    logic signed [65:0] re_w, im_w, mre_w, mim_w, orth_w, acc, resid;
    logic signed [63:0] r64;
    logic [64:0]        total;
    int                 n, dof, stride, k, idx;
    total = '0;
    res.saturated = 1'b0;
    n = (ortho_count > ORTHO_ROWS) ? ORTHO_ROWS : int'(ortho_count);
    if (!gap && n > 0) begin
      dof = (max_dof == 0) ? 1 : int'(max_dof);
      if (dof > n) dof = n;
      stride = n / dof;
      re_w = re;
      im_w = im;
      for (k = 0; k < n; k += stride) begin
        idx    = k * PAIRS + int'(pair);
        mre_w  = coef_re_tab[idx];
        mim_w  = coef_im_tab[idx];
        orth_w = ortho_tab[k];
        acc = re_w * mre_w + im_w * mim_w;
        if (acc > SUM_CLAMP) acc = SUM_CLAMP;
        if (acc < -SUM_CLAMP) acc = -SUM_CLAMP;
        acc   = acc - (orth_w <<< 16) + 66'sd32768;
        resid = acc >>> 16;
        if (resid > RES_MAX) begin
          res.saturated = 1'b1;
          resid = RES_MAX;
        end else if (resid < RES_MIN) begin
          res.saturated = 1'b1;
          resid = RES_MIN;
        end
        r64   = resid[63:0];
        total = total + 65'(r64 * r64);
        if (total[64]) begin
          total = {1'b0, {CHISQ_W{1'b1}}};
          res.saturated = 1'b1;
        end
      end
    end
    res.chisq = total[CHISQ_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    chisq_result_t due;
    if (!rst_ni) begin
      ortho_count = ORTHO_COUNT_RST;
      max_dof     = MAX_DOF_RST;
      chisq_due_q.delete();
      mismatch_count_o <= 0;
      due_count_o      <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (chisq_due_q.size() == 0) begin
          $display("%0t unexpected result: chisq %h saturated %b", $time, chisq_i,
                   saturated_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          due = chisq_due_q.pop_front();
          if (chisq_i !== due.chisq || saturated_i !== due.saturated) begin
            if (chisq_i !== due.chisq)
              $display("%0t chisq mismatch: expected %h actual %h", $time, due.chisq,
                       chisq_i);
            if (saturated_i !== due.saturated)
              $display("%0t saturated mismatch: expected %b actual %b", $time,
                       due.saturated, saturated_i);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_ORTHO_COUNT) ortho_count = cfg_data_i;
        else max_dof = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        case (opcode_i)
          OP_LOAD_COEF: begin
            coef_re_tab[int'(row_index_i) * PAIRS + int'(pair_index_i)] = value_re_i;
            coef_im_tab[int'(row_index_i) * PAIRS + int'(pair_index_i)] = value_im_i;
          end
          OP_LOAD_ORTHO: begin
            ortho_tab[row_index_i] = value_re_i;
          end
          OP_COMPUTE: begin
            chisq_due_q.push_back(projected_chisq(value_re_i, value_im_i, pair_index_i,
                                                  gap_i));
          end
          default: ;
        endcase
      end
      due_count_o <= chisq_due_q.size();
    end
  end

endmodule

// ----- sim/complex_projection_chisq_unit_test.sv -----
`timescale 1ns / 1ps
// Top of the complex projection chi-square unit test: clock, reset, config writes and
// item stimulus under three idling mixes. Depends on cpc_pkg, the unit and its checker.
module complex_projection_chisq_unit_test;
  import cpc_pkg::*;

  localparam int          ORTHO_ROWS   = 64;
  localparam int          PAIRS        = 32;
  localparam int          DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    cfg_valid_i  = 1'b0;
  logic                    cfg_ready_o;
  logic [0:0]              cfg_index_i  = '0;
  logic [CFG_W-1:0]        cfg_data_i   = '0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              opcode_i     = '0;
  logic [ROW_W-1:0]        row_index_i  = '0;
  logic [PAIR_W-1:0]       pair_index_i = '0;
  logic signed [VAL_W-1:0] value_re_i   = '0;
  logic signed [VAL_W-1:0] value_im_i   = '0;
  logic                    gap_i        = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic [CHISQ_W-1:0]      chisq_o;
  logic                    saturated_o;

  int          mismatch_count;
  int          due_count;
  int unsigned cycle_count   = 0;
  int          send_idle     = 0;
  int          recv_idle     = 0;
  int          items_sent    = 0;
  logic [CFG_W-1:0] cur_oc   = ORTHO_COUNT_RST;
  logic [CFG_W-1:0] cur_md   = MAX_DOF_RST;
  bit          coef_written  [0:ORTHO_ROWS*PAIRS-1];
  bit          ortho_written [0:ORTHO_ROWS-1];

  complex_projection_chisq_unit dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .opcode_i, .row_index_i, .pair_index_i,
    .value_re_i, .value_im_i, .gap_i, .out_valid_o, .out_ready_i, .chisq_o,
    .saturated_o
  );

  complex_projection_chisq_checker chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .opcode_i, .row_index_i, .pair_index_i,
    .value_re_i, .value_im_i, .gap_i, .out_valid_i(out_valid_o), .out_ready_i,
    .chisq_i(chisq_o), .saturated_i(saturated_o), .mismatch_count_o(mismatch_count),
    .due_count_o(due_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3, 4, 5: return 32'($urandom_range(196608)) - 32'd98304;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_cfg();
    case ($urandom_range(7))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'd127;
      4:       return CFG_W'($urandom_range(127));
      default: return CFG_W'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [ROW_W-1:0] row,
                           input logic [PAIR_W-1:0] pair, input logic [VAL_W-1:0] re,
                           input logic [VAL_W-1:0] im, input logic gap);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    row_index_i  <= row;
    pair_index_i <= pair;
    value_re_i   <= re;
    value_im_i   <= im;
    gap_i        <= gap;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (op == OP_LOAD_COEF) coef_written[int'(row) * PAIRS + int'(pair)] = 1'b1;
    if (op == OP_LOAD_ORTHO) ortho_written[row] = 1'b1;
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Load any table entry the next compute would read that has not been written yet.
  task automatic compute_pair(input logic [PAIR_W-1:0] pair, input logic [VAL_W-1:0] re,
                              input logic [VAL_W-1:0] im, input logic gap);
    int n, dof, stride, k;
    n = (cur_oc > ORTHO_ROWS) ? ORTHO_ROWS : int'(cur_oc);
    if (!gap && n > 0) begin
      dof = (cur_md == 0) ? 1 : int'(cur_md);
      if (dof > n) dof = n;
      stride = n / dof;
      for (k = 0; k < n; k += stride) begin
        if (!ortho_written[k])
          send_item(OP_LOAD_ORTHO, ROW_W'(k), PAIR_W'($urandom_range(31)), rand_value(),
                    rand_value(), 1'($urandom_range(1)));
        if (!coef_written[k * PAIRS + int'(pair)])
          send_item(OP_LOAD_COEF, ROW_W'(k), pair, rand_value(), rand_value(),
                    1'($urandom_range(1)));
      end
    end
    send_item(OP_COMPUTE, ROW_W'($urandom_range(63)), pair, re, im, gap);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [CFG_W-1:0] oc, input logic [CFG_W-1:0] md);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_ORTHO_COUNT;
    cfg_data_i  <= oc;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CFG_MAX_DOF;
    cfg_data_i  <= md;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_oc = oc;
    cur_md = md;
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(19);
    if (pick < 7)
      send_item(OP_LOAD_COEF, ROW_W'($urandom_range(63)), PAIR_W'($urandom_range(31)),
                rand_value(), rand_value(), 1'($urandom_range(1)));
    else if (pick < 10)
      send_item(OP_LOAD_ORTHO, ROW_W'($urandom_range(63)), PAIR_W'($urandom_range(31)),
                rand_value(), rand_value(), 1'($urandom_range(1)));
    else if (pick < 19)
      compute_pair(PAIR_W'($urandom_range(31)), rand_value(), rand_value(),
                   ($urandom_range(7) == 0));
    else
      send_item(OP_UNUSED, ROW_W'($urandom_range(63)), PAIR_W'($urandom_range(31)),
                $urandom(), $urandom(), 1'($urandom_range(1)));
  endtask

  task automatic run_random(input int count);
    int stop_items, next_cfg;
    stop_items = items_sent + count;
    next_cfg   = items_sent + 45;
    while (items_sent < stop_items) begin
      if (items_sent >= next_cfg) begin
        write_config(rand_cfg(), rand_cfg());
        next_cfg = items_sent + 45;
      end
      random_item();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 16;
    recv_idle = 83;
    write_config(7'd1, 7'd5);
    // extremes, gap on loads, ignored imaginary part on ortho loads
    send_item(OP_LOAD_ORTHO, '0, '0, 32'h7FFF_FFFF, 32'h1234_5678, 1'b1);
    send_item(OP_LOAD_COEF, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    compute_pair(5'd0, 32'h8000_0000, 32'h8000_0000, 1'b0);
    compute_pair(5'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    compute_pair(5'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    compute_pair(5'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_item(OP_UNUSED, 6'd63, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // rounding ties on both sides of zero
    send_item(OP_LOAD_ORTHO, '0, '0, '0, '0, 1'b0);
    send_item(OP_LOAD_COEF, '0, 5'd1, 32'h0000_8000, '0, 1'b0);
    compute_pair(5'd1, 32'h0000_0001, '0, 1'b0);
    compute_pair(5'd1, 32'hFFFF_FFFF, '0, 1'b0);
    compute_pair(5'd31, '0, '0, 1'b0);
    write_config(7'd0, 7'd5);
    compute_pair(5'd0, 32'h0001_0000, 32'h0001_0000, 1'b0);
    write_config(7'd127, 7'd0);
    compute_pair(5'd0, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0);
    write_config(7'd64, 7'd64);
    compute_pair(5'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    write_config(7'd64, 7'd127);
    compute_pair(5'd2, 32'h8000_0000, 32'h0000_0000, 1'b0);
    write_config(7'd6, 7'd3);
    run_random(85);

    send_idle = 83;
    recv_idle = 16;
    run_random(85);

    send_idle = 0;
    recv_idle = 0;
    run_random(85);

    settle();
    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
